// File: sv/lht_pkg.sv
// Shared constants, types and helper functions for the linear hash table.
// Used by lht_front, lht_engine and linear_hash_table; depends on nothing.
`default_nettype none

package lht_pkg;

  localparam int BASE_BUCKETS    = 16;
  localparam int SLOTS_PER_TABLE = 16;
  localparam int MAX_BUCKETS     = 1024;
  localparam int OVERFLOW_TABLES = 512;

  localparam int TABLE_COUNT = MAX_BUCKETS + OVERFLOW_TABLES;
  localparam int SLOT_COUNT  = TABLE_COUNT * SLOTS_PER_TABLE;
  // Longest possible chain: one bucket table plus every overflow table.
  localparam int WORK_DEPTH  = (OVERFLOW_TABLES + 1) * SLOTS_PER_TABLE;

  localparam int OP_W   = 2;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 15;
  localparam int THR_W  = 4;
  localparam int BKT_W  = $clog2(MAX_BUCKETS);
  localparam int TBL_W  = $clog2(TABLE_COUNT);
  localparam int SLOT_W = $clog2(SLOTS_PER_TABLE);
  localparam int FILL_W = $clog2(SLOTS_PER_TABLE + 1);
  localparam int CODE_W = $clog2(OVERFLOW_TABLES + 1);
  localparam int KV_AW  = $clog2(SLOT_COUNT);
  localparam int WK_AW  = $clog2(WORK_DEPTH);
  localparam int WK_W   = $clog2(WORK_DEPTH + 1);
  localparam int LVL_W  = $clog2($clog2(MAX_BUCKETS / BASE_BUCKETS) + 1);
  localparam int BIU_W  = $clog2(MAX_BUCKETS + 1);
  localparam int LOAD_W = CNT_W + THR_W;

  localparam int LOAD_SCALE = 10;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(9);
  localparam int REQ_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT,
    OP_GET,
    OP_REMOVE,
    OP_UPDATE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [BKT_W-1:0] hash;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] entry_count;
  } res_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [CODE_W-1:0] link;
  } tab_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } kv_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_TRD,
    ST_W_TCHK,
    ST_W_SRD,
    ST_W_SCHK,
    ST_W_END,
    ST_R_MV,
    ST_R_PREV,
    ST_AP_START,
    ST_AP_FREAD,
    ST_AP_LINK,
    ST_SP_TEST,
    ST_X_TRD,
    ST_X_TCHK,
    ST_X_SRD,
    ST_X_SCHK,
    ST_X_END,
    ST_X_CHECK,
    ST_F_RD,
    ST_F_WR,
    ST_Z_B,
    ST_Z_NB,
    ST_C_RD,
    ST_C_GO,
    ST_SP_END,
    ST_DONE
  } eng_state_t;

  // Low bits of key*3; only these bits ever reach a bucket index.
  function automatic logic [BKT_W-1:0] hash_low(input logic [KEY_W-1:0] key);
    return key[BKT_W-1:0] + {key[BKT_W-2:0], 1'b0};
  endfunction

  // Overflow table codes are the overflow table's index (table number minus MAX_BUCKETS) plus one, zero meaning none.
  function automatic logic [TBL_W-1:0] table_of(input logic [CODE_W-1:0] code);
    return TBL_W'(MAX_BUCKETS) + TBL_W'(code) - TBL_W'(1);
  endfunction

  function automatic logic [CODE_W-1:0] code_of(input logic [TBL_W-1:0] tbl);
    logic [TBL_W-1:0] diff;
    diff = tbl - TBL_W'(MAX_BUCKETS) + TBL_W'(1);
    return diff[CODE_W-1:0];
  endfunction

  function automatic logic [WK_W-1:0] tables_needed(input logic [WK_W-1:0] entries);
    return (entries == '0) ? '0 : ((entries - WK_W'(1)) >> SLOT_W);
  endfunction

endpackage

`default_nettype wire

// File: sv/lht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; used for the key-value, table and work memories of the engine.
`default_nettype none

module lht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: sv/lht_fifo.sv
// Small register-based first-in first-out queue.
// Stands alone; parts the request and result sides from the engine.
`default_nettype none

module lht_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: sv/lht_front.sv
// Front end: takes requests, decodes the operation, hashes the key and queues them.
// Depends on lht_pkg and lht_fifo.
`default_nettype none

module lht_front
  import lht_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [OP_W-1:0]  in_operation,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [VAL_W-1:0] in_value,
  input  wire logic             clearing,
  output logic                  req_valid,
  input  wire logic             req_pop,
  output req_t                  req
);

  req_t                 req_in;
  logic [$bits(req_t)-1:0] q_rd;
  logic                 q_full, q_empty;

  always_comb begin
    req_in.op    = op_t'(in_operation);
    req_in.key   = in_key;
    req_in.value = in_value;
    req_in.hash  = hash_low(in_key);
  end

  // No request enters while the table memory is still being cleared.
  assign full = q_full || clearing;

  lht_fifo #(
    .WIDTH($bits(req_t)),
    .DEPTH(REQ_DEPTH)
  ) u_req_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push && !full),
    .wr_data(req_in),
    .full   (q_full),
    .rd_en  (req_pop),
    .rd_data(q_rd),
    .empty  (q_empty)
  );

  assign req_valid = !q_empty;
  assign req       = req_t'(q_rd);

endmodule

`default_nettype wire

// File: sv/lht_engine.sv
// Back end: walks bucket chains, performs insert, get, remove and update,
// and splits buckets. Depends on lht_pkg and lht_ram.
`default_nettype none

module lht_engine
  import lht_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [THR_W-1:0] split_load,
  input  wire logic             req_valid,
  input  req_t                  req,
  output logic                  req_pop,
  input  wire logic             res_full,
  output logic                  res_push,
  output res_t                  res,
  output logic                  clearing
);

  // Memories
  logic             kv_we;
  logic [KV_AW-1:0] kv_waddr, kv_raddr;
  kv_t              kv_wdata, kv_rdata;
  logic             tab_we;
  logic [TBL_W-1:0] tab_waddr, tab_raddr;
  tab_t             tab_wdata, tab_rdata;
  logic             wk_we;
  logic [WK_AW-1:0] wk_waddr, wk_raddr;
  kv_t              wk_wdata, wk_rdata;

  // Control state
  eng_state_t        state_r, state_nxt;
  logic [TBL_W-1:0]  clr_r, clr_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [BKT_W-1:0]  sp_r, sp_nxt;
  logic [BIU_W-1:0]  biu_r, biu_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CODE_W-1:0] ovu_r, ovu_nxt;
  logic [CODE_W-1:0] fhead_r, fhead_nxt;
  logic [CODE_W-1:0] fcnt_r, fcnt_nxt;

  // Per-request working registers
  op_t               op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [TBL_W-1:0]  t_r, t_nxt;
  logic [TBL_W-1:0]  prev_r, prev_nxt;
  logic [FILL_W-1:0] prev_fill_r, prev_fill_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CODE_W-1:0] link_r, link_nxt;
  logic [FILL_W-1:0] i_r, i_nxt;
  logic              found_r, found_nxt;
  logic [KV_AW-1:0]  hole_r, hole_nxt;
  logic [VAL_W-1:0]  hole_val_r, hole_val_nxt;
  logic              ok_r, ok_nxt;
  logic [VAL_W-1:0]  rv_r, rv_nxt;
  logic [TBL_W-1:0]  ap_tail_r, ap_tail_nxt;
  logic [FILL_W-1:0] ap_fill_r, ap_fill_nxt;
  logic [KEY_W-1:0]  ap_key_r, ap_key_nxt;
  logic [VAL_W-1:0]  ap_val_r, ap_val_nxt;
  logic [CODE_W-1:0] ap_code_r, ap_code_nxt;
  eng_state_t        ap_ret_r, ap_ret_nxt;
  logic [BKT_W-1:0]  bkt_r, bkt_nxt;
  logic [BKT_W-1:0]  nb_r, nb_nxt;
  logic [WK_W-1:0]   stay_r, stay_nxt;
  logic [WK_W-1:0]   moved_r, moved_nxt;
  logic [CODE_W-1:0] oldov_r, oldov_nxt;
  logic [CODE_W-1:0] blink_r, blink_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [WK_W-1:0]   ci_r, ci_nxt;
  logic              copy_mv_r, copy_mv_nxt;

  // Derived values
  logic [BKT_W:0]    n_full, n_dbl;
  logic [BKT_W-1:0]  mask_n, mask_2n;
  logic [BKT_W-1:0]  req_bkt;
  logic [BKT_W:0]    nb_sum;
  logic [LOAD_W-1:0] load_lhs, load_rhs;
  logic [WK_W:0]     need_sum, have_sum;
  logic              pool_empty;

  assign n_full  = (BKT_W + 1)'(BASE_BUCKETS) << level_r;
  assign n_dbl   = n_full << 1;
  assign mask_n  = BKT_W'(n_full - (BKT_W + 1)'(1));
  assign mask_2n = BKT_W'(n_dbl - (BKT_W + 1)'(1));
  assign nb_sum  = (BKT_W + 1)'(sp_r) + n_full;

  // Buckets below the split pointer have already been split and use the wider mask.
  assign req_bkt = ((req.hash & mask_n) < sp_r) ? (req.hash & mask_2n) : (req.hash & mask_n);

  assign load_lhs = LOAD_W'(total_r) * LOAD_W'(LOAD_SCALE);
  assign load_rhs = LOAD_W'(split_load) * LOAD_W'(SLOTS_PER_TABLE) * LOAD_W'(biu_r);

  assign need_sum = (WK_W + 1)'(tables_needed(stay_r)) + (WK_W + 1)'(tables_needed(moved_r));
  assign have_sum = (WK_W + 1)'(oldov_r) + (WK_W + 1)'(fcnt_r);

  assign pool_empty = (fhead_r == '0) && (ovu_r >= CODE_W'(OVERFLOW_TABLES));

  assign clearing = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    level_nxt     = level_r;
    sp_nxt        = sp_r;
    biu_nxt       = biu_r;
    total_nxt     = total_r;
    ovu_nxt       = ovu_r;
    fhead_nxt     = fhead_r;
    fcnt_nxt      = fcnt_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    t_nxt         = t_r;
    prev_nxt      = prev_r;
    prev_fill_nxt = prev_fill_r;
    fill_nxt      = fill_r;
    link_nxt      = link_r;
    i_nxt         = i_r;
    found_nxt     = found_r;
    hole_nxt      = hole_r;
    hole_val_nxt  = hole_val_r;
    ok_nxt        = ok_r;
    rv_nxt        = rv_r;
    ap_tail_nxt   = ap_tail_r;
    ap_fill_nxt   = ap_fill_r;
    ap_key_nxt    = ap_key_r;
    ap_val_nxt    = ap_val_r;
    ap_code_nxt   = ap_code_r;
    ap_ret_nxt    = ap_ret_r;
    bkt_nxt       = bkt_r;
    nb_nxt        = nb_r;
    stay_nxt      = stay_r;
    moved_nxt     = moved_r;
    oldov_nxt     = oldov_r;
    blink_nxt     = blink_r;
    code_nxt      = code_r;
    ci_nxt        = ci_r;
    copy_mv_nxt   = copy_mv_r;

    kv_we     = 1'b0;
    kv_waddr  = hole_r;
    kv_wdata  = '{key: key_r, value: val_r};
    kv_raddr  = {t_r, i_r[SLOT_W-1:0]};
    tab_we    = 1'b0;
    tab_waddr = t_r;
    tab_wdata = '0;
    tab_raddr = t_r;
    wk_we     = 1'b0;
    wk_waddr  = stay_r[WK_AW-1:0];
    wk_wdata  = kv_rdata;
    wk_raddr  = ci_r[WK_AW-1:0];
    req_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '{ok: ok_r, read_value: rv_r, entry_count: total_r};

    unique case (state_r)
      ST_CLEAR: begin
        tab_we    = 1'b1;
        tab_waddr = clr_r;
        clr_nxt   = clr_r + TBL_W'(1);
        if (clr_r == TBL_W'(TABLE_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_valid && !res_full) begin
          req_pop   = 1'b1;
          op_nxt    = req.op;
          key_nxt   = req.key;
          val_nxt   = req.value;
          t_nxt     = TBL_W'(req_bkt);
          prev_nxt  = TBL_W'(req_bkt);
          found_nxt = 1'b0;
          ok_nxt    = 1'b0;
          rv_nxt    = '0;
          if (req.op == OP_INSERT && pool_empty) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_W_TRD;
          end
        end
      end

      ST_W_TRD: begin
        state_nxt = ST_W_TCHK;
      end

      ST_W_TCHK: begin
        fill_nxt = tab_rdata.fill;
        link_nxt = tab_rdata.link;
        i_nxt    = '0;
        if (!found_r && tab_rdata.fill != '0) begin
          state_nxt = ST_W_SRD;
        end else begin
          state_nxt = ST_W_END;
        end
      end

      ST_W_SRD: begin
        state_nxt = ST_W_SCHK;
      end

      ST_W_SCHK: begin
        i_nxt = i_r + FILL_W'(1);
        if (kv_rdata.key == key_r) begin
          found_nxt    = 1'b1;
          hole_nxt     = {t_r, i_r[SLOT_W-1:0]};
          hole_val_nxt = kv_rdata.value;
          state_nxt    = ST_W_END;
        end else if (i_r + FILL_W'(1) == fill_r) begin
          state_nxt = ST_W_END;
        end else begin
          state_nxt = ST_W_SRD;
        end
      end

      // The whole chain is walked so that its last table is known on exit.
      ST_W_END: begin
        if (link_r != '0) begin
          prev_nxt      = t_r;
          prev_fill_nxt = fill_r;
          t_nxt         = table_of(link_r);
          state_nxt     = ST_W_TRD;
        end else begin
          case (op_r)
            OP_GET: begin
              ok_nxt    = found_r;
              rv_nxt    = found_r ? hole_val_r : '0;
              state_nxt = ST_DONE;
            end
            OP_UPDATE: begin
              ok_nxt    = found_r;
              kv_we     = found_r;
              state_nxt = ST_DONE;
            end
            OP_REMOVE: begin
              kv_raddr = {t_r, i_r[SLOT_W-1:0]};
              if (found_r) begin
                kv_raddr  = {t_r, SLOT_W'(fill_r - FILL_W'(1))};
                state_nxt = ST_R_MV;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            default: begin
              ok_nxt = 1'b1;
              if (found_r) begin
                state_nxt = ST_SP_TEST;
              end else begin
                total_nxt   = total_r + CNT_W'(1);
                ap_tail_nxt = t_r;
                ap_fill_nxt = fill_r;
                ap_key_nxt  = key_r;
                ap_val_nxt  = val_r;
                ap_ret_nxt  = ST_SP_TEST;
                state_nxt   = ST_AP_START;
              end
            end
          endcase
        end
      end

      // The chain's last entry fills the hole left by the removed key.
      ST_R_MV: begin
        kv_we     = 1'b1;
        kv_wdata  = kv_rdata;
        ok_nxt    = 1'b1;
        total_nxt = total_r - CNT_W'(1);
        tab_we    = 1'b1;
        if (fill_r == FILL_W'(1) && t_r >= TBL_W'(MAX_BUCKETS)) begin
          tab_wdata = '{fill: '0, link: fhead_r};
          fhead_nxt = code_of(t_r);
          fcnt_nxt  = fcnt_r + CODE_W'(1);
          state_nxt = ST_R_PREV;
        end else begin
          tab_wdata = '{fill: fill_r - FILL_W'(1), link: '0};
          state_nxt = ST_DONE;
        end
      end

      ST_R_PREV: begin
        tab_we    = 1'b1;
        tab_waddr = prev_r;
        tab_wdata = '{fill: prev_fill_r, link: '0};
        state_nxt = ST_DONE;
      end

      ST_AP_START: begin
        tab_raddr = table_of(fhead_r);
        if (ap_fill_r < FILL_W'(SLOTS_PER_TABLE)) begin
          kv_we       = 1'b1;
          kv_waddr    = {ap_tail_r, ap_fill_r[SLOT_W-1:0]};
          kv_wdata    = '{key: ap_key_r, value: ap_val_r};
          tab_we      = 1'b1;
          tab_waddr   = ap_tail_r;
          tab_wdata   = '{fill: ap_fill_r + FILL_W'(1), link: '0};
          ap_fill_nxt = ap_fill_r + FILL_W'(1);
          state_nxt   = ap_ret_r;
        end else if (fhead_r != '0) begin
          state_nxt = ST_AP_FREAD;
        end else begin
          ap_code_nxt = ovu_r + CODE_W'(1);
          ovu_nxt     = ovu_r + CODE_W'(1);
          state_nxt   = ST_AP_LINK;
        end
      end

      ST_AP_FREAD: begin
        ap_code_nxt = fhead_r;
        fhead_nxt   = tab_rdata.link;
        state_nxt   = ST_AP_LINK;
      end

      ST_AP_LINK: begin
        tab_we      = 1'b1;
        tab_waddr   = ap_tail_r;
        tab_wdata   = '{fill: FILL_W'(SLOTS_PER_TABLE), link: ap_code_r};
        ap_tail_nxt = table_of(ap_code_r);
        ap_fill_nxt = '0;
        fcnt_nxt    = fcnt_r - CODE_W'(1);
        state_nxt   = ST_AP_START;
      end

      ST_SP_TEST: begin
        if (biu_r < BIU_W'(MAX_BUCKETS) && nb_sum < (BKT_W + 1)'(MAX_BUCKETS) &&
            load_lhs > load_rhs) begin
          bkt_nxt   = sp_r;
          nb_nxt    = BKT_W'(nb_sum);
          t_nxt     = TBL_W'(sp_r);
          stay_nxt  = '0;
          moved_nxt = '0;
          oldov_nxt = '0;
          state_nxt = ST_X_TRD;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_X_TRD: begin
        state_nxt = ST_X_TCHK;
      end

      ST_X_TCHK: begin
        fill_nxt = tab_rdata.fill;
        link_nxt = tab_rdata.link;
        i_nxt    = '0;
        if (t_r == TBL_W'(bkt_r)) begin
          blink_nxt = tab_rdata.link;
        end
        if (tab_rdata.fill != '0) begin
          state_nxt = ST_X_SRD;
        end else begin
          state_nxt = ST_X_END;
        end
      end

      ST_X_SRD: begin
        state_nxt = ST_X_SCHK;
      end

      // Entries that stay fill the work buffer from the bottom, movers from the top.
      ST_X_SCHK: begin
        wk_we = 1'b1;
        i_nxt = i_r + FILL_W'(1);
        if ((hash_low(kv_rdata.key) & mask_2n) == bkt_r) begin
          wk_waddr = stay_r[WK_AW-1:0];
          stay_nxt = stay_r + WK_W'(1);
        end else begin
          wk_waddr  = WK_AW'(WK_W'(WORK_DEPTH - 1) - moved_r);
          moved_nxt = moved_r + WK_W'(1);
        end
        if (i_r + FILL_W'(1) == fill_r) begin
          state_nxt = ST_X_END;
        end else begin
          state_nxt = ST_X_SRD;
        end
      end

      ST_X_END: begin
        if (link_r != '0) begin
          oldov_nxt = oldov_r + CODE_W'(1);
          t_nxt     = table_of(link_r);
          state_nxt = ST_X_TRD;
        end else begin
          state_nxt = ST_X_CHECK;
        end
      end

      ST_X_CHECK: begin
        if (need_sum > have_sum) begin
          state_nxt = ST_DONE;
        end else begin
          code_nxt  = blink_r;
          state_nxt = ST_F_RD;
        end
      end

      ST_F_RD: begin
        tab_raddr = table_of(code_r);
        if (code_r != '0) begin
          state_nxt = ST_F_WR;
        end else begin
          state_nxt = ST_Z_B;
        end
      end

      ST_F_WR: begin
        tab_we    = 1'b1;
        tab_waddr = table_of(code_r);
        tab_wdata = '{fill: '0, link: fhead_r};
        fhead_nxt = code_r;
        fcnt_nxt  = fcnt_r + CODE_W'(1);
        code_nxt  = tab_rdata.link;
        state_nxt = ST_F_RD;
      end

      ST_Z_B: begin
        tab_we    = 1'b1;
        tab_waddr = TBL_W'(bkt_r);
        state_nxt = ST_Z_NB;
      end

      ST_Z_NB: begin
        tab_we      = 1'b1;
        tab_waddr   = TBL_W'(nb_r);
        ci_nxt      = '0;
        copy_mv_nxt = 1'b0;
        ap_tail_nxt = TBL_W'(bkt_r);
        ap_fill_nxt = '0;
        state_nxt   = ST_C_RD;
      end

      ST_C_RD: begin
        if (!copy_mv_r) begin
          wk_raddr = ci_r[WK_AW-1:0];
          if (ci_r < stay_r) begin
            state_nxt = ST_C_GO;
          end else begin
            copy_mv_nxt = 1'b1;
            ci_nxt      = '0;
            ap_tail_nxt = TBL_W'(nb_r);
            ap_fill_nxt = '0;
          end
        end else begin
          wk_raddr = WK_AW'(WK_W'(WORK_DEPTH - 1) - ci_r);
          if (ci_r < moved_r) begin
            state_nxt = ST_C_GO;
          end else begin
            state_nxt = ST_SP_END;
          end
        end
      end

      ST_C_GO: begin
        ap_key_nxt = wk_rdata.key;
        ap_val_nxt = wk_rdata.value;
        ci_nxt     = ci_r + WK_W'(1);
        ap_ret_nxt = ST_C_RD;
        state_nxt  = ST_AP_START;
      end

      ST_SP_END: begin
        biu_nxt = biu_r + BIU_W'(1);
        if ((BKT_W + 1)'(sp_r) + (BKT_W + 1)'(1) == n_full) begin
          sp_nxt    = '0;
          level_nxt = level_r + LVL_W'(1);
        end else begin
          sp_nxt = sp_r + BKT_W'(1);
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      level_r <= '0;
      sp_r    <= '0;
      biu_r   <= BIU_W'(BASE_BUCKETS);
      total_r <= '0;
      ovu_r   <= '0;
      fhead_r <= '0;
      fcnt_r  <= CODE_W'(OVERFLOW_TABLES);
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      level_r <= level_nxt;
      sp_r    <= sp_nxt;
      biu_r   <= biu_nxt;
      total_r <= total_nxt;
      ovu_r   <= ovu_nxt;
      fhead_r <= fhead_nxt;
      fcnt_r  <= fcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    t_r         <= t_nxt;
    prev_r      <= prev_nxt;
    prev_fill_r <= prev_fill_nxt;
    fill_r      <= fill_nxt;
    link_r      <= link_nxt;
    i_r         <= i_nxt;
    found_r     <= found_nxt;
    hole_r      <= hole_nxt;
    hole_val_r  <= hole_val_nxt;
    ok_r        <= ok_nxt;
    rv_r        <= rv_nxt;
    ap_tail_r   <= ap_tail_nxt;
    ap_fill_r   <= ap_fill_nxt;
    ap_key_r    <= ap_key_nxt;
    ap_val_r    <= ap_val_nxt;
    ap_code_r   <= ap_code_nxt;
    ap_ret_r    <= ap_ret_nxt;
    bkt_r       <= bkt_nxt;
    nb_r        <= nb_nxt;
    stay_r      <= stay_nxt;
    moved_r     <= moved_nxt;
    oldov_r     <= oldov_nxt;
    blink_r     <= blink_nxt;
    code_r      <= code_nxt;
    ci_r        <= ci_nxt;
    copy_mv_r   <= copy_mv_nxt;
  end

  lht_ram #(
    .WIDTH($bits(kv_t)),
    .DEPTH(SLOT_COUNT)
  ) u_kv_ram (
    .clk  (clk),
    .we   (kv_we),
    .waddr(kv_waddr),
    .wdata(kv_wdata),
    .raddr(kv_raddr),
    .rdata(kv_rdata)
  );

  lht_ram #(
    .WIDTH($bits(tab_t)),
    .DEPTH(TABLE_COUNT)
  ) u_tab_ram (
    .clk  (clk),
    .we   (tab_we),
    .waddr(tab_waddr),
    .wdata(tab_wdata),
    .raddr(tab_raddr),
    .rdata(tab_rdata)
  );

  lht_ram #(
    .WIDTH($bits(kv_t)),
    .DEPTH(WORK_DEPTH)
  ) u_work_ram (
    .clk  (clk),
    .we   (wk_we),
    .waddr(wk_waddr),
    .wdata(wk_wdata),
    .raddr(wk_raddr),
    .rdata(wk_rdata)
  );

endmodule

`default_nettype wire

// File: sv/linear_hash_table.sv
// Linear-hashing key-value store: each request inserts, gets, removes or updates a
// 64-bit key and returns one result. After reset the table memory is cleared, one table
// per cycle, all 1536 tables, during which full stays high. A request then reads each
// table of its bucket chain and compares its slots (a lookup stops comparing at the hit
// but still follows the chain's links), then moves or appends an entry where needed. An
// insert that finds the load over the split threshold also splits one bucket: the old
// chain is read into a work buffer, table by table and entry by entry, and written back
// entry by entry, taking overflow tables as needed.
// Each table memory has a single read port. Two requests and two results can wait in
// queues on either side of the engine.
// Depends on lht_pkg, lht_fifo, lht_front and lht_engine.
`default_nettype none

module linear_hash_table
  import lht_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [OP_W-1:0]  in_operation,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [VAL_W-1:0] in_value,
  output logic                  empty,
  input  wire logic             pop,
  output logic                  out_ok,
  output logic      [VAL_W-1:0] out_read_value,
  output logic      [CNT_W-1:0] out_entry_count,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  localparam logic REG_SPLIT_LOAD = 1'b0;

  logic [THR_W-1:0] thr_r, thr_nxt;
  logic             clearing;
  logic             req_valid, req_pop;
  req_t             req;
  logic             res_push, res_full;
  res_t             res_in, res_out;
  logic [$bits(res_t)-1:0] res_rd;

  assign pready = 1'b1;

  always_comb begin
    thr_nxt = thr_r;
    if (psel && penable && pwrite && paddr[2] == REG_SPLIT_LOAD) begin
      thr_nxt = pwdata[THR_W-1:0];
    end
    prdata = (paddr[2] == REG_SPLIT_LOAD) ? {(32 - THR_W)'(0), thr_r} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  lht_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_operation(in_operation),
    .in_key      (in_key),
    .in_value    (in_value),
    .clearing    (clearing),
    .req_valid   (req_valid),
    .req_pop     (req_pop),
    .req         (req)
  );

  lht_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .split_load(thr_r),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .clearing  (clearing)
  );

  lht_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_data(res_in),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(res_rd),
    .empty  (empty)
  );

  assign res_out         = res_t'(res_rd);
  assign out_ok          = res_out.ok;
  assign out_read_value  = res_out.read_value;
  assign out_entry_count = res_out.entry_count;

endmodule

`default_nettype wire
